[design/astar_pkg.sv]
// Shared types and constants for the A* shortest path engine.
package astar_pkg;

	typedef enum logic [1:0] {
		CMD_ADJ    = 2'd0,
		CMD_INDEX  = 2'd1,
		CMD_DIST   = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	localparam int CmdWidth    = 2;
	localparam int NodeWidth   = 6;
	localparam int SlotWidth   = 9;
	localparam int ValueWidth  = 32;
	localparam int MetresWidth = 24;
	localparam int CountWidth  = 7;

	// graph sizes, fixed by the field widths of a transaction
	localparam int MAX_NODES  = 64;
	localparam int ADJ_WORDS  = 512;
	localparam int DIST_WIDTH = 32;

	localparam logic [3:0] RegNodeCount = 4'd0;

endpackage

[design/astar_shortest_path.sv]
// A* shortest path engine: graph stores, binary min-heap and search sequencer.
//
// Channel | Direction | Contents
// s_axis  | in        | tdata: command[1:0], node_a[7:2], node_b[13:8], slot[22:14], value[54:23]
// m_axis  | out       | tdata: path_metres[23:0]; tuser: unreachable
// apb     | in/out    | node_count at address 0
//
// Loads take one cycle each; s_axis_tready drops for one cycle after each load.
// Search: set-up, then per popped node a heap pop, sift-down level by level, an expansion and
// a visit of each neighbour word (skipped, or relaxed and, when pushed, sifted up step by step);
// goal or out-of-range start/goal: on to the result.
// Reset clears control state and node_count (to MAX_NODES); stores are undefined.
// A finished result waits in the output register; loads and a new search are taken meanwhile.
module astar_shortest_path (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command, node_a, node_b, slot, value from bit 0 up; zero padded
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// path_metres
	output logic [23:0] m_axis_tdata,
	// unreachable
	output logic        m_axis_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import astar_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int AW = $clog2(ADJ_WORDS);
	localparam int HW = $clog2(MAX_NODES + 1);
	localparam logic [DIST_WIDTH-1:0] DistMax = '1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_INIT, ST_INIT_KEY, ST_POP, ST_POP_RD, ST_POP_LAST, ST_POP_CHK,
		ST_SD_L, ST_SD_R, ST_SD_CMP, ST_DEG, ST_DEG_RD, ST_NB_RD, ST_NB, ST_NB_COST,
		ST_NB_CMP, ST_NB_NEXT, ST_PUSH_H, ST_PUSH, ST_SU_RD, ST_SU_CMP, ST_NEXT,
		ST_GOAL, ST_DONE
	} state_t;

	state_t state_q;

	// input fields
	logic [1:0]            in_cmd;
	logic [5:0]            in_a, in_b;
	logic [8:0]            in_slot;
	logic [31:0]           in_value;
	assign in_cmd   = s_axis_tdata[1:0];
	assign in_a     = s_axis_tdata[7:2];
	assign in_b     = s_axis_tdata[13:8];
	assign in_slot  = s_axis_tdata[22:14];
	assign in_value = s_axis_tdata[54:23];

	logic [CountWidth-1:0] node_count_q;
	logic [HW:0]           n_eff;
	always_comb begin
		if (node_count_q == '0)
			n_eff = (HW+1)'(1);
		else if (32'(node_count_q) > MAX_NODES)
			n_eff = (HW+1)'(MAX_NODES);
		else
			n_eff = (HW+1)'(node_count_q);
	end

	// memories
	logic [6:0]            adj_mem [ADJ_WORDS];
	logic [AW-1:0]         idx_mem [MAX_NODES];
	logic [DIST_WIDTH-1:0] dist_mem [MAX_NODES*MAX_NODES];
	logic [NW-1:0]         heap_node_mem [MAX_NODES];
	logic [DIST_WIDTH-1:0] heap_key_mem [MAX_NODES];
	logic [DIST_WIDTH-1:0] cost_mem [MAX_NODES];
	logic [MAX_NODES-1:0]  closed_q, open_q;

	logic [6:0]            adj_rd_q;
	logic [AW-1:0]         idx_rd_q;
	logic [DIST_WIDTH-1:0] dist_rd_q, cost_rd_q, hkey_rd_q;
	logic [NW-1:0]         hnode_rd_q;

	logic [AW-1:0]         adj_ra;
	logic [NW-1:0]         idx_ra, cost_ra, heap_ra;
	logic [2*NW-1:0]       dist_ra;
	logic                  cost_we, heap_we;
	logic [NW-1:0]         cost_wa, heap_wa, heap_wnode;
	logic [DIST_WIDTH-1:0] cost_wd, heap_wkey;

	logic                  load_adj, load_idx, load_dist, accept;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign load_adj  = accept && in_cmd == CMD_ADJ;
	assign load_idx  = accept && in_cmd == CMD_INDEX && 32'(in_a) < MAX_NODES;
	assign load_dist = accept && in_cmd == CMD_DIST && 32'(in_a) < MAX_NODES
		&& 32'(in_b) < MAX_NODES;

	always_ff @(posedge clk) begin
		if (load_adj)
			adj_mem[AW'(32'(in_slot) % ADJ_WORDS)] <= in_value[6:0];
		adj_rd_q <= adj_mem[adj_ra];
	end
	always_ff @(posedge clk) begin
		if (load_idx)
			idx_mem[NW'(in_a)] <= AW'(in_value % ADJ_WORDS);
		idx_rd_q <= idx_mem[idx_ra];
	end
	always_ff @(posedge clk) begin
		if (load_dist)
			dist_mem[{NW'(in_a), NW'(in_b)}] <= in_value[DIST_WIDTH-1:0];
		dist_rd_q <= dist_mem[dist_ra];
	end
	always_ff @(posedge clk) begin
		if (cost_we)
			cost_mem[cost_wa] <= cost_wd;
		cost_rd_q <= cost_mem[cost_ra];
	end
	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_node_mem[heap_wa] <= heap_wnode;
			heap_key_mem[heap_wa]  <= heap_wkey;
		end
		hnode_rd_q <= heap_node_mem[heap_ra];
		hkey_rd_q  <= heap_key_mem[heap_ra];
	end

	// search registers
	logic [NW-1:0]         start_q, goal_q, cur_q, nbr_q;
	logic [HW-1:0]         hcount_q, pos_q, bottom_q;
	logic [DIST_WIDTH-1:0] gcur_q, t_q, key_q, lkey_q;
	logic [NW-1:0]         mnode_q, lnode_q;
	logic [AW-1:0]         base_q;
	logic [6:0]            deg_q, k_q;
	logic                  load_busy_q;
	logic [23:0]           res_metres_q;
	logic                  res_unreach_q;

	// shared unit: saturating add and a compare
	logic [DIST_WIDTH-1:0] add_a, add_b, add_sum, cmp_a, cmp_b;
	logic [DIST_WIDTH:0]   add_full;
	logic                  cmp_gt;
	assign add_full = {1'b0, add_a} + {1'b0, add_b};
	assign add_sum  = add_full[DIST_WIDTH] ? DistMax : add_full[DIST_WIDTH-1:0];
	assign cmp_gt   = cmp_a > cmp_b;

	logic [HW:0] left_w, right_w, parent_w;
	assign left_w   = {pos_q, 1'b1};
	assign right_w  = {pos_q, 1'b0} + (HW+1)'(2);
	assign parent_w = (HW+1)'((pos_q - HW'(1)) >> 1);

	// smaller child for sift-down; ties go right
	logic                  pick_right;
	logic [DIST_WIDTH-1:0] ckey;
	logic [NW-1:0]         cnode;
	logic [HW:0]           child_w;
	assign pick_right = left_w != {1'b0, bottom_q} && lkey_q >= hkey_rd_q;
	assign ckey       = pick_right ? hkey_rd_q : lkey_q;
	assign cnode      = pick_right ? hnode_rd_q : lnode_q;
	assign child_w    = pick_right ? right_w : left_w;

	logic [DIST_WIDTH+1:0] metres_w;
	assign metres_w = ({2'b0, gcur_q} + (DIST_WIDTH+2)'(128)) >> 8;

	always_comb begin
		adj_ra  = base_q;
		idx_ra  = cur_q;
		cost_ra = cur_q;
		heap_ra = NW'(pos_q);
		dist_ra = {cur_q, goal_q};
		cost_we = 1'b0;
		cost_wa = nbr_q;
		cost_wd = add_sum;
		heap_we = 1'b0;
		heap_wa = NW'(pos_q);
		heap_wnode = mnode_q;
		heap_wkey  = key_q;
		add_a = gcur_q;
		add_b = dist_rd_q;
		cmp_a = key_q;
		cmp_b = ckey;
		case (state_q)
			ST_INIT: begin
				dist_ra = {start_q, goal_q};
				cost_we = 1'b1;
				cost_wa = start_q;
				cost_wd = '0;
			end
			ST_INIT_KEY: begin
				heap_we    = 1'b1;
				heap_wa    = '0;
				heap_wnode = start_q;
				heap_wkey  = dist_rd_q;
			end
			ST_POP:      heap_ra = '0;
			ST_POP_RD:   heap_ra = NW'(hcount_q - HW'(1));
			ST_SD_L: begin
				heap_ra = NW'(left_w);
				heap_we = left_w > {1'b0, bottom_q};
			end
			ST_SD_R:     heap_ra = NW'(right_w);
			ST_SD_CMP: begin
				heap_we = 1'b1;
				if (cmp_gt) begin
					heap_wnode = cnode;
					heap_wkey  = ckey;
				end
			end
			ST_NB_RD:    adj_ra = AW'(32'(base_q) + 32'(k_q));
			ST_NB_COST: begin
				cost_ra = nbr_q;
				dist_ra = {cur_q, nbr_q};
			end
			ST_NB_CMP: begin
				cmp_a   = cost_rd_q;
				cmp_b   = add_sum;
				cost_we = !open_q[nbr_q] || cmp_gt;
			end
			ST_PUSH_H:   dist_ra = {nbr_q, goal_q};
			ST_PUSH:     add_a = t_q;
			ST_SU_RD: begin
				heap_ra = NW'(parent_w);
				heap_we = pos_q == '0;
			end
			ST_SU_CMP: begin
				cmp_a   = hkey_rd_q;
				cmp_b   = key_q;
				heap_we = 1'b1;
				if (cmp_gt) begin
					heap_wnode = hnode_rd_q;
					heap_wkey  = hkey_rd_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			node_count_q  <= CountWidth'(MAX_NODES);
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
			hcount_q      <= '0;
			closed_q      <= '0;
			open_q        <= '0;
			load_busy_q   <= 1'b0;
			start_q       <= '0;
			goal_q        <= '0;
			cur_q         <= '0;
			nbr_q         <= '0;
			pos_q         <= '0;
			bottom_q      <= '0;
			gcur_q        <= '0;
			t_q           <= '0;
			key_q         <= '0;
			lkey_q        <= '0;
			mnode_q       <= '0;
			lnode_q       <= '0;
			base_q        <= '0;
			deg_q         <= '0;
			k_q           <= '0;
			res_metres_q  <= '0;
			res_unreach_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == RegNodeCount[1:0])
				node_count_q <= pwdata[CountWidth-1:0];
			if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			load_busy_q <= accept && in_cmd != CMD_SEARCH;
			case (state_q)
				ST_IDLE: begin
					if (accept && in_cmd == CMD_SEARCH) begin
						start_q <= NW'(in_a);
						goal_q  <= NW'(in_b);
						if ({1'b0, HW'(in_a)} >= n_eff || {1'b0, HW'(in_b)} >= n_eff) begin
							res_metres_q  <= '0;
							res_unreach_q <= 1'b1;
							state_q       <= ST_DONE;
						end else begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					closed_q <= '0;
					open_q   <= MAX_NODES'(1) << start_q;
					state_q  <= ST_INIT_KEY;
				end
				ST_INIT_KEY: begin
					hcount_q <= HW'(1);
					state_q  <= ST_POP;
				end
				ST_POP: state_q <= ST_POP_RD;
				ST_POP_RD: begin
					cur_q   <= hnode_rd_q;
					state_q <= ST_POP_LAST;
				end
				ST_POP_LAST: begin
					// last entry, to be moved to the root
					mnode_q <= hnode_rd_q;
					key_q   <= hkey_rd_q;
					state_q <= ST_POP_CHK;
				end
				ST_POP_CHK: begin
					gcur_q <= cost_rd_q;
					base_q <= idx_rd_q;
					if (cur_q == goal_q) begin
						state_q <= ST_GOAL;
					end else begin
						open_q[cur_q]   <= 1'b0;
						closed_q[cur_q] <= 1'b1;
						hcount_q        <= hcount_q - HW'(1);
						if (hcount_q > HW'(1)) begin
							bottom_q <= hcount_q - HW'(2);
							pos_q    <= '0;
							state_q  <= ST_SD_L;
						end else begin
							state_q <= ST_DEG;
						end
					end
				end
				ST_SD_L: begin
					if (left_w > {1'b0, bottom_q})
						state_q <= ST_DEG;
					else
						state_q <= ST_SD_R;
				end
				ST_SD_R: begin
					lkey_q  <= hkey_rd_q;
					lnode_q <= hnode_rd_q;
					state_q <= ST_SD_CMP;
				end
				ST_SD_CMP: begin
					if (cmp_gt) begin
						pos_q   <= HW'(child_w);
						state_q <= ST_SD_L;
					end else begin
						state_q <= ST_DEG;
					end
				end
				ST_DEG: begin
					k_q     <= 7'd1;
					state_q <= ST_DEG_RD;
				end
				ST_DEG_RD: begin
					deg_q   <= adj_rd_q;
					state_q <= (adj_rd_q == '0) ? ST_NEXT : ST_NB_RD;
				end
				ST_NB_RD: state_q <= ST_NB;
				ST_NB: begin
					nbr_q <= NW'(adj_rd_q);
					if ({1'b0, adj_rd_q} >= n_eff || closed_q[NW'(adj_rd_q)])
						state_q <= ST_NB_NEXT;
					else
						state_q <= ST_NB_COST;
				end
				ST_NB_COST: state_q <= ST_NB_CMP;
				ST_NB_CMP: begin
					t_q <= add_sum;
					if (!open_q[nbr_q] && 32'(hcount_q) < MAX_NODES)
						state_q <= ST_PUSH_H;
					else
						state_q <= ST_NB_NEXT;
				end
				ST_NB_NEXT: begin
					k_q     <= k_q + 7'd1;
					state_q <= (k_q == deg_q) ? ST_NEXT : ST_NB_RD;
				end
				ST_PUSH_H: state_q <= ST_PUSH;
				ST_PUSH: begin
					key_q         <= add_sum;
					mnode_q       <= nbr_q;
					open_q[nbr_q] <= 1'b1;
					pos_q         <= hcount_q;
					hcount_q      <= hcount_q + HW'(1);
					state_q       <= ST_SU_RD;
				end
				ST_SU_RD: state_q <= (pos_q == '0) ? ST_NB_NEXT : ST_SU_CMP;
				ST_SU_CMP: begin
					if (cmp_gt) begin
						pos_q   <= HW'(parent_w);
						state_q <= ST_SU_RD;
					end else begin
						state_q <= ST_NB_NEXT;
					end
				end
				ST_NEXT: begin
					if (hcount_q == '0) begin
						res_metres_q  <= '0;
						res_unreach_q <= 1'b1;
						state_q       <= ST_DONE;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_GOAL: begin
					res_metres_q  <= (metres_w > (DIST_WIDTH+2)'(24'hFFFFFF))
						? 24'hFFFFFF : 24'(metres_w);
					res_unreach_q <= 1'b0;
					state_q       <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_axis_tvalid) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= res_metres_q;
						m_axis_tuser  <= res_unreach_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = state_q == ST_IDLE && !load_busy_q;
	assign prdata = {{(32-CountWidth){1'b0}}, node_count_q};
	assign pready = 1'b1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));
	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hcount_q) <= MAX_NODES);
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == ST_IDLE);
	a_pready: assert property (@(posedge clk) pready);

endmodule

[tb/sv/astar_shortest_path_tb.sv]
// Testbench for the A* shortest path engine: loads, searches and a route-cost predictor.
module astar_shortest_path_tb;
	import astar_pkg::*;

	typedef struct {
		logic [MetresWidth-1:0] metres;
		logic                   unreach;
	} route_t;

	typedef struct {
		bit                    cfg;
		cmd_t                  cmd;
		logic [NodeWidth-1:0]  a;
		logic [NodeWidth-1:0]  b;
		logic [SlotWidth-1:0]  slot;
		logic [ValueWidth-1:0] value;
		bit                    typed;
		logic [MetresWidth-1:0] metres;
		logic                  unreach;
	} row_t;

	localparam longint unsigned DistMax = 64'hFFFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	astar_shortest_path dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor copy of the graph stores, with written marks
	logic [6:0]  adj_mem [512];
	logic [8:0]  offs_mem [64];
	logic [31:0] dist_mem [4096];
	bit          adj_set [512];
	bit          offs_set [64];
	bit          dist_set [4096];
	logic [6:0]  node_cnt = 7'd64;

	// search scratch
	int              hp_node [64];
	longint unsigned hp_key [64];
	int              hp_cnt;
	longint unsigned g_cost [64];
	bit              closed_m [64];
	bit              open_m [64];
	bit              touched_unset;

	route_t      route_q [$];
	int unsigned errors = 0;
	int unsigned items = 0;
	int          tx_idle = 0;
	int          rx_stall = 0;
	int          hold_epoch = 0;

	row_t dir_rows [26] = '{
		'{0, CMD_ADJ,    0, 0, 510, 32'hFFFF_FF82, 0, 0, 0},
		'{0, CMD_ADJ,    0, 0, 511, 32'd2,         0, 0, 0},
		'{0, CMD_ADJ,    0, 0, 0,   32'd0,         0, 0, 0},
		'{0, CMD_ADJ,    0, 0, 3,   32'd2,         0, 0, 0},
		'{0, CMD_ADJ,    0, 0, 4,   32'd1,         0, 0, 0},
		'{0, CMD_ADJ,    0, 0, 5,   32'd100,       0, 0, 0},
		'{0, CMD_ADJ,    0, 0, 6,   32'h80,        0, 0, 0},
		'{0, CMD_INDEX,  0, 0, 0,   32'hFFFF_FE03, 0, 0, 0},
		'{0, CMD_INDEX,  1, 0, 0,   32'd510,       0, 0, 0},
		'{0, CMD_INDEX,  2, 0, 0,   32'd6,         0, 0, 0},
		'{0, CMD_DIST,   0, 0, 0,   32'd0,         0, 0, 0},
		'{0, CMD_DIST,   0, 2, 0,   32'h300,       0, 0, 0},
		'{0, CMD_DIST,   0, 1, 0,   32'h180,       0, 0, 0},
		'{0, CMD_DIST,   1, 2, 0,   32'hFFFF_FFFF, 0, 0, 0},
		'{0, CMD_DIST,   2, 2, 0,   32'd0,         0, 0, 0},
		'{0, CMD_DIST,   2, 0, 0,   32'h40,        0, 0, 0},
		'{0, CMD_DIST,   1, 0, 0,   32'h7FF,       0, 0, 0},
		'{0, CMD_SEARCH, 0, 0, 0,   32'd0,         1, 24'd0, 1'b0},
		'{0, CMD_SEARCH, 0, 2, 0,   32'd0,         1, 24'hFFFFFF, 1'b0},
		'{0, CMD_SEARCH, 2, 0, 0,   32'd0,         1, 24'd0, 1'b1},
		'{0, CMD_DIST,   1, 2, 0,   32'h100,       0, 0, 0},
		'{0, CMD_SEARCH, 0, 2, 0,   32'd0,         0, 0, 0},
		'{0, CMD_SEARCH, 1, 2, 0,   32'd0,         0, 0, 0},
		'{1, CMD_ADJ,    0, 0, 0,   32'd0,         0, 0, 0},
		'{0, CMD_SEARCH, 0, 0, 0,   32'd0,         1, 24'd0, 1'b0},
		'{0, CMD_SEARCH, 0, 2, 0,   32'd0,         1, 24'd0, 1'b1}
	};

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint unsigned sat_sum(longint unsigned x, longint unsigned y);
		longint unsigned s;
		s = x + y;
		return (s > DistMax) ? DistMax : s;
	endfunction

	function automatic longint unsigned dist_at(int r, int c);
		if (!dist_set[r * 64 + c])
			touched_unset = 1'b1;
		return longint'(dist_mem[r * 64 + c]);
	endfunction

	function automatic void heap_swap(int x, int y);
		int              tn;
		longint unsigned tk;
		tn = hp_node[x]; tk = hp_key[x];
		hp_node[x] = hp_node[y]; hp_key[x] = hp_key[y];
		hp_node[y] = tn; hp_key[y] = tk;
	endfunction

	function automatic void heap_down(int bottom);
		int root, left, right, mn;
		root = 0;
		left = 1;
		while (left <= bottom) begin
			right = root * 2 + 2;
			if (left == bottom)
				mn = left;
			else
				mn = (hp_key[left] >= hp_key[right]) ? right : left;
			if (hp_key[root] > hp_key[mn]) begin
				heap_swap(root, mn);
				root = mn;
				left = root * 2 + 1;
			end else begin
				break;
			end
		end
	endfunction

	function automatic void heap_up(int pos);
		int parent;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (hp_key[parent] > hp_key[pos]) begin
				heap_swap(parent, pos);
				pos = parent;
			end else begin
				break;
			end
		end
	endfunction

	// A* with stale heap keys; sets touched_unset if any store entry read was never loaded
	function automatic void route_cost(input int s, input int gl, output route_t r);
		int              n, cur, base, deg, k, idx, nbr;
		longint unsigned t, mm;
		n = node_cnt;
		if (n < 1) n = 1;
		if (n > 64) n = 64;
		r.metres = '0;
		r.unreach = 1'b1;
		touched_unset = 1'b0;
		if (s >= n || gl >= n)
			return;
		for (k = 0; k < 64; k++) begin
			closed_m[k] = 1'b0;
			open_m[k] = 1'b0;
		end
		g_cost[s] = 0;
		hp_node[0] = s;
		hp_key[0] = dist_at(s, gl);
		open_m[s] = 1'b1;
		hp_cnt = 1;
		while (hp_cnt > 0) begin
			cur = hp_node[0];
			if (hp_cnt > 1) begin
				hp_node[0] = hp_node[hp_cnt - 1];
				hp_key[0] = hp_key[hp_cnt - 1];
				heap_down(hp_cnt - 2);
			end
			if (cur == gl) begin
				mm = (g_cost[cur] + 128) >> 8;
				r.metres = (mm > 64'hFF_FFFF) ? 24'hFF_FFFF : mm[23:0];
				r.unreach = 1'b0;
				return;
			end
			open_m[cur] = 1'b0;
			hp_cnt--;
			closed_m[cur] = 1'b1;
			if (!offs_set[cur]) touched_unset = 1'b1;
			base = offs_mem[cur];
			if (!adj_set[base]) touched_unset = 1'b1;
			deg = adj_mem[base];
			for (k = 1; k <= deg; k++) begin
				idx = (base + k) % 512;
				if (!adj_set[idx]) touched_unset = 1'b1;
				nbr = adj_mem[idx];
				if (nbr >= n || closed_m[nbr])
					continue;
				t = sat_sum(g_cost[cur], dist_at(cur, nbr));
				if (!open_m[nbr] || t < g_cost[nbr]) begin
					g_cost[nbr] = t;
					if (!open_m[nbr] && hp_cnt < 64) begin
						hp_node[hp_cnt] = nbr;
						hp_key[hp_cnt] = sat_sum(t, dist_at(nbr, gl));
						heap_up(hp_cnt);
						open_m[nbr] = 1'b1;
						hp_cnt++;
					end
				end
			end
		end
	endfunction

	// offer one transaction, wait for acceptance, then update the predictor
	task automatic send(input row_t row);
		route_t r;
		if ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, row.value, row.slot, row.b, row.a, row.cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items++;
		case (row.cmd)
			CMD_ADJ: begin
				adj_mem[row.slot] = row.value[6:0];
				adj_set[row.slot] = 1'b1;
			end
			CMD_INDEX: begin
				offs_mem[row.a] = row.value[8:0];
				offs_set[row.a] = 1'b1;
			end
			CMD_DIST: begin
				dist_mem[{row.a, row.b}] = row.value;
				dist_set[{row.a, row.b}] = 1'b1;
			end
			default: begin
				route_cost(row.a, row.b, r);
				if (row.typed) begin
					r.metres = row.metres;
					r.unreach = row.unreach;
				end
				route_q.push_back(r);
			end
		endcase
	endtask

	task automatic load(input cmd_t c, input int a, input int b, input int sl,
			input logic [31:0] v);
		row_t row;
		row = '{0, c, a[5:0], b[5:0], sl[8:0], v, 0, 0, 0};
		send(row);
	endtask

	// called straight after an accept, so tvalid drops before a repeat can be taken
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (route_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(4 * RegNodeCount);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		node_cnt = v[6:0];
	endtask

	function automatic logic [31:0] rand_dist();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return $urandom_range(0, 4095);
		if (pick < 90) return $urandom;
		return 32'hFFFF_FFFF;
	endfunction

	// lay out a fresh graph over nodes 0..n-1 with distance columns for two goals
	task automatic build_graph(input int n, input int g0, input int g1);
		int pos, i, k, deg, nbr, maxdeg;
		pos = $urandom_range(0, 511);
		maxdeg = (n > 16) ? 4 : 6;
		for (i = 0; i < n; i++) begin
			deg = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, maxdeg);
			load(CMD_INDEX, i, $urandom_range(0, 63), $urandom_range(0, 511),
				($urandom & ~32'h1FF) | pos);
			load(CMD_ADJ, 0, 0, pos, ($urandom & ~32'h7F) | deg);
			for (k = 1; k <= deg; k++) begin
				nbr = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, n - 1);
				load(CMD_ADJ, $urandom_range(0, 63), 0, (pos + k) % 512,
					($urandom & ~32'h7F) | nbr);
				if (nbr < n)
					load(CMD_DIST, i, nbr, $urandom_range(0, 511), rand_dist());
			end
			pos = (pos + deg + 1) % 512;
			load(CMD_DIST, i, g0, 0, rand_dist());
			if (g1 != g0)
				load(CMD_DIST, i, g1, 0, rand_dist());
		end
	endtask

	// receiver: random stalls, plus a long hold-off whenever the epoch moves on
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_epoch) begin
				hold_seen = hold_epoch;
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= rx_stall);
		end
	end

	always @(posedge clk) begin
		route_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (route_q.size() == 0) begin
				$display("%0t: unexpected result metres=%0d unreachable=%0b",
					$time, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = route_q.pop_front();
				if (m_axis_tdata !== want.metres) begin
					$display("%0t: path_metres expected %0d actual %0d",
						$time, want.metres, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.unreach) begin
					$display("%0t: unreachable expected %0b actual %0b",
						$time, want.unreach, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int     i, p, n, g0, g1, tries, searches, s, gl, c;
		logic [6:0] cfgv;
		route_t r;
		row_t   row;
		for (i = 0; i < 512; i++) begin
			adj_mem[i] = '0;
			adj_set[i] = 1'b0;
		end
		for (i = 0; i < 64; i++) begin
			offs_mem[i] = '0;
			offs_set[i] = 1'b0;
		end
		for (i = 0; i < 4096; i++) begin
			dist_mem[i] = '0;
			dist_set[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg) begin
				drain();
				cfg_write(dir_rows[i].value);
			end else begin
				send(dir_rows[i]);
			end
		end
		drain();

		p = 0;
		while (items < 1850) begin
			case (p % 4)
				0: begin tx_idle = 0;  rx_stall = 0;  end
				1: begin tx_idle = 69; rx_stall = 0;  end
				2: begin tx_idle = 0;  rx_stall = 69; end
				default: begin tx_idle = 24; rx_stall = 24; end
			endcase
			case (p)
				0: cfgv = 7'd127;
				1: cfgv = 7'd0;
				5: cfgv = 7'd64;
				default: cfgv = 7'($urandom_range(2, 14));
			endcase
			cfg_write({25'd0, cfgv});
			n = (cfgv == 0) ? 1 : ((cfgv > 64) ? 64 : cfgv);
			g0 = $urandom_range(0, n - 1);
			g1 = $urandom_range(0, n - 1);
			build_graph(n, g0, g1);
			if (p == 2)
				hold_epoch++;
			searches = (n >= 32) ? 12 : 40;
			while (searches > 0) begin
				if ($urandom_range(99) < 15) begin
					c = $urandom_range(0, 2);
					row = '{0, cmd_t'(c), 6'($urandom), 6'($urandom), 9'($urandom),
						$urandom, 0, 0, 0};
					send(row);
					continue;
				end
				tries = 0;
				do begin
					if ($urandom_range(99) < 85) begin
						s = $urandom_range(0, n - 1);
						gl = $urandom_range(1) ? g0 : g1;
					end else begin
						s = $urandom_range(0, 63);
						gl = $urandom_range(0, 63);
					end
					route_cost(s, gl, r);
					tries++;
				end while (touched_unset && tries < 20);
				searches--;
				if (!touched_unset)
					load(CMD_SEARCH, s, gl, $urandom_range(0, 511), $urandom);
			end
			drain();
			p++;
		end

		while (route_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
